[rtl/pmsh_pkg.sv]
// Package for the pad merge block: sizes, d-pad direction codes, button bit
// positions and sound-cue codes.
// No dependencies.
package pmsh_pkg;

	localparam int PAD_COUNT = 7;
	localparam int PAD_AW    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam int SLOT_W    = 3;
	localparam int SLOT_XW   = (PAD_AW > SLOT_W) ? PAD_AW : SLOT_W;
	localparam int WORD_W    = 14;
	localparam int THR_W     = 8;
	localparam int AXIS_W    = 8;
	localparam int DIR_W     = 3;
	localparam int CUE_W     = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [THR_W-1:0] ENGAGE_RESET  = 8'd80;
	localparam logic [THR_W-1:0] RELEASE_RESET = 8'd50;
	localparam logic signed [AXIS_W:0] STICK_CENTRE = 9'sd128;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENGAGE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'd1;

	// stick directions
	localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

	// button bit positions
	localparam int BIT_UP       = 0;
	localparam int BIT_DOWN     = 1;
	localparam int BIT_LEFT     = 2;
	localparam int BIT_RIGHT    = 3;
	localparam int BIT_CROSS    = 4;
	localparam int BIT_CIRCLE   = 5;
	localparam int BIT_TRIANGLE = 7;
	localparam int BIT_L1       = 10;
	localparam int BIT_R1       = 11;

	// sound cues
	localparam logic [CUE_W-1:0] CUE_NONE   = 3'd0;
	localparam logic [CUE_W-1:0] CUE_DECIDE = 3'd1;
	localparam logic [CUE_W-1:0] CUE_CANCEL = 3'd2;
	localparam logic [CUE_W-1:0] CUE_OPTION = 3'd3;
	localparam logic [CUE_W-1:0] CUE_CURSOR = 3'd4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [DIR_W-1:0]  dir_t;

endpackage

[rtl/pad_merge_stick_hysteresis_edges.sv]
// A frame-end word is registered in stage 1, then its result in the output register.
// Throughput: one pad word per cycle while the input is not stalled; the stick
// direction store is read in the accept cycle and written back from stage 1, with
// a bypass for back-to-back reports of the same slot. Input stalls only while a frame
// result waits. Reset clears all stick directions at once through per-slot
// valid flags, the frame state and the thresholds (80 and 50).
module pad_merge_stick_hysteresis_edges
	import pmsh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SLOT_W-1:0]    pad_slot,
	input  logic                 delivered,
	input  logic [WORD_W-1:0]    button_bits,
	input  logic                 has_stick,
	input  logic [AXIS_W-1:0]    stick_horizontal,
	input  logic [AXIS_W-1:0]    stick_vertical,
	input  logic                 frame_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    held_buttons,
	output logic [WORD_W-1:0]    pressed_edges,
	output logic [CUE_W-1:0]     sound_cue,
	output logic                 any_delivered
);

	localparam int VBITS = 1 << PAD_AW;

	logic [THR_W-1:0] engage_q, release_q;

	// stage 1 registers
	logic              valid_s1;
	logic [PAD_AW-1:0] addr_s1;
	logic              in_range_s1;
	logic              delivered_s1;
	word_t             buttons_s1;
	logic              has_stick_s1;
	logic [AXIS_W-1:0] stick_h_s1, stick_v_s1;
	logic              frame_end_s1;

	logic [VBITS-1:0]  dir_valid_q;
	logic              byp_valid_q;
	logic [PAD_AW-1:0] byp_addr_q;
	dir_t              byp_dir_q;

	word_t acc_q, current_q;
	logic  any_q;

	logic              out_valid_q;
	word_t             held_q, edges_q;
	logic [CUE_W-1:0]  cue_q;
	logic              out_any_q;

	logic [SLOT_XW-1:0] slot_x;
	logic [PAD_AW-1:0]  in_addr, rd_addr;
	logic               in_range;
	logic               in_fire, fire_s1, out_free;
	dir_t               ram_rdata, prev_dir, cand_dir, new_dir;
	logic               contrib, dir_write;

	logic signed [AXIS_W:0]   dx, dy;
	logic        [AXIS_W:0]   ax, ay, major;
	logic signed [AXIS_W+1:0] lean;
	logic                     engaged, keep;

	word_t dir_bits, acc_next, cur_next, edges_next;
	logic  any_next;
	logic [CUE_W-1:0] cue_next;

	assign slot_x   = SLOT_XW'(pad_slot);
	assign in_addr  = slot_x[PAD_AW-1:0];
	assign in_range = slot_x < SLOT_XW'(PAD_COUNT);

	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && (!frame_end_s1 || out_free);
	assign in_stall = valid_s1 && !fire_s1;
	assign in_fire  = in_valid && !in_stall;

	// re-read the held slot while stage 1 waits for the output
	assign rd_addr = in_stall ? addr_s1 : in_addr;

	assign contrib   = in_range_s1 && delivered_s1;
	assign dir_write = fire_s1 && contrib && has_stick_s1;

	pmsh_ram #(
		.WIDTH(DIR_W),
		.DEPTH(PAD_COUNT)
	) u_dir_ram (
		.clk  (clk),
		.we   (dir_write),
		.waddr(addr_s1),
		.wdata(new_dir),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engage_q  <= ENGAGE_RESET;
			release_q <= RELEASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENGAGE:  engage_q  <= cfg_data;
				CFG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_s1      <= in_addr;
			in_range_s1  <= in_range;
			delivered_s1 <= delivered;
			buttons_s1   <= button_bits;
			has_stick_s1 <= has_stick;
			stick_h_s1   <= stick_horizontal;
			stick_v_s1   <= stick_vertical;
			frame_end_s1 <= frame_end;
		end
	end

	// bypass the word written at the same edge the next read was taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_valid_q <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			byp_valid_q <= dir_write;
			if (dir_write) begin
				dir_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dir_write) begin
			byp_addr_q <= addr_s1;
			byp_dir_q  <= new_dir;
		end
	end

	always_comb begin
		if (byp_valid_q && byp_addr_q == addr_s1) begin
			prev_dir = byp_dir_q;
		end else if (dir_valid_q[addr_s1]) begin
			prev_dir = ram_rdata;
		end else begin
			prev_dir = DIR_NONE;
		end
	end

	// direction with hysteresis
	always_comb begin
		dx      = $signed({1'b0, stick_h_s1}) - STICK_CENTRE;
		dy      = $signed({1'b0, stick_v_s1}) - STICK_CENTRE;
		ax      = dx[AXIS_W] ? (AXIS_W+1)'(-dx) : (AXIS_W+1)'(dx);
		ay      = dy[AXIS_W] ? (AXIS_W+1)'(-dy) : (AXIS_W+1)'(dy);
		major   = (ax > ay) ? ax : ay;
		engaged = major > {1'b0, engage_q};

		if (!engaged) begin
			cand_dir = DIR_NONE;
		end else if (ax > ay) begin
			cand_dir = dx[AXIS_W] ? DIR_LEFT : DIR_RIGHT;
		end else begin
			cand_dir = dy[AXIS_W] ? DIR_UP : DIR_DOWN;
		end

		unique case (prev_dir)
			DIR_UP:    lean = -{dy[AXIS_W], dy};
			DIR_DOWN:  lean = {dy[AXIS_W], dy};
			DIR_LEFT:  lean = -{dx[AXIS_W], dx};
			DIR_RIGHT: lean = {dx[AXIS_W], dx};
			default:   lean = '0;
		endcase

		keep = (prev_dir != DIR_NONE) && (lean > $signed({2'b00, release_q}))
			&& (cand_dir == DIR_NONE || cand_dir == prev_dir);
		new_dir = keep ? prev_dir : cand_dir;
	end

	always_comb begin
		dir_bits = '0;
		if (has_stick_s1) begin
			case (new_dir)
				DIR_UP:    dir_bits[BIT_UP]    = 1'b1;
				DIR_DOWN:  dir_bits[BIT_DOWN]  = 1'b1;
				DIR_LEFT:  dir_bits[BIT_LEFT]  = 1'b1;
				DIR_RIGHT: dir_bits[BIT_RIGHT] = 1'b1;
				default: ;
			endcase
		end

		acc_next = contrib ? (acc_q | buttons_s1 | dir_bits) : acc_q;
		any_next = any_q || contrib;

		if (any_next) begin
			cur_next   = acc_next;
			edges_next = acc_next & ~current_q;
		end else begin
			cur_next   = current_q;
			edges_next = '0;
		end

		if (edges_next[BIT_CROSS]) begin
			cue_next = CUE_DECIDE;
		end else if (edges_next[BIT_CIRCLE]) begin
			cue_next = CUE_CANCEL;
		end else if (edges_next[BIT_TRIANGLE]) begin
			cue_next = CUE_OPTION;
		end else if (edges_next[BIT_L1] || edges_next[BIT_R1]) begin
			cue_next = CUE_CURSOR;
		end else begin
			cue_next = CUE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			any_q     <= 1'b0;
			current_q <= '0;
		end else if (fire_s1) begin
			if (frame_end_s1) begin
				acc_q     <= '0;
				any_q     <= 1'b0;
				current_q <= cur_next;
			end else begin
				acc_q <= acc_next;
				any_q <= any_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && frame_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && frame_end_s1) begin
			held_q    <= cur_next;
			edges_q   <= edges_next;
			cue_q     <= cue_next;
			out_any_q <= any_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign held_buttons  = held_q;
	assign pressed_edges = edges_q;
	assign sound_cue     = cue_q;
	assign any_delivered = out_any_q;

endmodule

[rtl/pmsh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/pmsh_checker.sv]
// Port-level checks for the pad merge block, bound to its top level.
// Depends on pmsh_pkg and pad_merge_stick_hysteresis_edges.
module pmsh_checker
	import pmsh_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] held_buttons,
	input logic [WORD_W-1:0] pressed_edges,
	input logic [CUE_W-1:0]  sound_cue,
	input logic              any_delivered
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(held_buttons)
			&& $stable(pressed_edges) && $stable(sound_cue))
		else $error("stalled result word changed");

	a_edges_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pressed_edges & ~held_buttons) == '0)
		else $error("press edge on a button not held");

	a_quiet_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !any_delivered |-> pressed_edges == '0 && sound_cue == CUE_NONE)
		else $error("edges or cue on a frame with no pad");

	a_decide_cue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressed_edges[BIT_CROSS] |-> sound_cue == CUE_DECIDE)
		else $error("cross press without decide cue");

endmodule

bind pad_merge_stick_hysteresis_edges pmsh_checker u_pmsh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.held_buttons (held_buttons),
	.pressed_edges(pressed_edges),
	.sound_cue    (sound_cue),
	.any_delivered(any_delivered)
);

[tb/pmsh_tb_pkg.sv]
// Types and frame scoreboard for the pad merge testbench: predicts the merged
// button word, press edges and sound cue of each frame and checks the block's output.
// Depends on pmsh_pkg.
package pmsh_tb_pkg;
	import pmsh_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              delivered;
		word_t             buttons;
		logic              has_stick;
		logic [AXIS_W-1:0] horiz;
		logic [AXIS_W-1:0] vert;
		logic              frame_end;
	} pad_report_t;

	typedef struct packed {
		word_t            held;
		word_t            edges;
		logic [CUE_W-1:0] cue;
		logic             any_dlv;
	} frame_result_t;

	class frame_scoreboard;
		logic [THR_W-1:0] engage_thr;
		logic [THR_W-1:0] keep_thr;
		dir_t             pad_dir[PAD_COUNT];
		word_t            frame_acc;
		logic             frame_seen;
		word_t            cur_word;
		word_t            prev_word;
		frame_result_t    expected_frames[$];
		int               errors;
		int               reports_noted;
		int               frames_checked;

		function new();
			engage_thr = ENGAGE_RESET;
			keep_thr   = RELEASE_RESET;
			foreach (pad_dir[i])
				pad_dir[i] = DIR_NONE;
			frame_acc      = '0;
			frame_seen     = 1'b0;
			cur_word       = '0;
			prev_word      = '0;
			errors         = 0;
			reports_noted  = 0;
			frames_checked = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] value);
			if (idx == CFG_ENGAGE)
				engage_thr = value;
			else if (idx == CFG_RELEASE)
				keep_thr = value;
		endfunction

		// hold the old direction while the stick still leans its way and
		// nothing else engages
		function dir_t step_direction(dir_t prev, int dx, int dy);
			int   ax;
			int   ay;
			int   major;
			int   lean;
			dir_t cand;
			ax    = (dx < 0) ? -dx : dx;
			ay    = (dy < 0) ? -dy : dy;
			major = (ax > ay) ? ax : ay;
			case (prev)
				DIR_UP:    lean = -dy;
				DIR_DOWN:  lean = dy;
				DIR_LEFT:  lean = -dx;
				DIR_RIGHT: lean = dx;
				default:   lean = 0;
			endcase
			if (major <= int'(engage_thr))
				cand = DIR_NONE;
			else if (ax > ay)
				cand = (dx < 0) ? DIR_LEFT : DIR_RIGHT;
			else
				cand = (dy < 0) ? DIR_UP : DIR_DOWN;
			if (prev != DIR_NONE && lean > int'(keep_thr) && (cand == DIR_NONE || cand == prev))
				return prev;
			return cand;
		endfunction

		function void note_report(pad_report_t r);
			dir_t          d;
			frame_result_t res;
			reports_noted++;
			if (r.delivered && r.slot < PAD_COUNT) begin
				frame_acc |= r.buttons;
				if (r.has_stick) begin
					d = step_direction(pad_dir[r.slot], int'(r.horiz) - 128,
						int'(r.vert) - 128);
					pad_dir[r.slot] = d;
					if (d != DIR_NONE)
						frame_acc |= word_t'(1) << (d - 1);
				end
				frame_seen = 1'b1;
			end
			if (!r.frame_end)
				return;
			prev_word = cur_word;
			res.edges = '0;
			res.cue   = CUE_NONE;
			if (frame_seen) begin
				cur_word  = frame_acc;
				res.edges = cur_word & ~prev_word;
				if (res.edges[BIT_CROSS])
					res.cue = CUE_DECIDE;
				else if (res.edges[BIT_CIRCLE])
					res.cue = CUE_CANCEL;
				else if (res.edges[BIT_TRIANGLE])
					res.cue = CUE_OPTION;
				else if (res.edges[BIT_L1] || res.edges[BIT_R1])
					res.cue = CUE_CURSOR;
			end
			res.held    = cur_word;
			res.any_dlv = frame_seen;
			expected_frames.push_back(res);
			frame_acc  = '0;
			frame_seen = 1'b0;
		endfunction

		function void check_frame(frame_result_t got);
			frame_result_t exp_res;
			frames_checked++;
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t: unexpected frame word held %h edges %h cue %0d any %0d",
					$time, got.held, got.edges, got.cue, got.any_dlv);
				return;
			end
			exp_res = expected_frames.pop_front();
			if (got.held !== exp_res.held) begin
				errors++;
				$display("%0t: held_buttons expected %h actual %h",
					$time, exp_res.held, got.held);
			end
			if (got.edges !== exp_res.edges) begin
				errors++;
				$display("%0t: pressed_edges expected %h actual %h",
					$time, exp_res.edges, got.edges);
			end
			if (got.cue !== exp_res.cue) begin
				errors++;
				$display("%0t: sound_cue expected %0d actual %0d",
					$time, exp_res.cue, got.cue);
			end
			if (got.any_dlv !== exp_res.any_dlv) begin
				errors++;
				$display("%0t: any_delivered expected %0d actual %0d",
					$time, exp_res.any_dlv, got.any_dlv);
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
// Top of the pad merge testbench: clock, reset, word drivers with random gaps
// and stalls, threshold phases and the final verdict.
// Depends on pmsh_pkg, pmsh_tb_pkg and the pad_merge_stick_hysteresis_edges RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pmsh_pkg::*;
	import pmsh_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD    = 80;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [SLOT_W-1:0]    pad_slot;
	logic                 delivered;
	logic [WORD_W-1:0]    button_bits;
	logic                 has_stick;
	logic [AXIS_W-1:0]    stick_horizontal;
	logic [AXIS_W-1:0]    stick_vertical;
	logic                 frame_end;
	logic                 out_valid;
	logic                 out_stall;
	logic [WORD_W-1:0]    held_buttons;
	logic [WORD_W-1:0]    pressed_edges;
	logic [CUE_W-1:0]     sound_cue;
	logic                 any_delivered;

	frame_scoreboard sb;
	int              cycles;
	int              stall_left;
	int              settings_done;
	bit              quiet;
	bit              long_hold_req;

	pad_merge_stick_hysteresis_edges DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pad_slot         (pad_slot),
		.delivered        (delivered),
		.button_bits      (button_bits),
		.has_stick        (has_stick),
		.stick_horizontal (stick_horizontal),
		.stick_vertical   (stick_vertical),
		.frame_end        (frame_end),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.held_buttons     (held_buttons),
		.pressed_edges    (pressed_edges),
		.sound_cue        (sound_cue),
		.any_delivered    (any_delivered)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// result side: check every word taken, then draw the stall before the next
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_frame('{held: held_buttons, edges: pressed_edges, cue: sound_cue,
				any_dlv: any_delivered});
			stall_left = quiet ? 0 : $urandom_range(0, 4);
		end
	end

	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic pad_report_t mk(int slot, bit dl, word_t btn, bit hs, int h, int v,
		bit fe);
		pad_report_t r;
		r.slot      = slot[SLOT_W-1:0];
		r.delivered = dl;
		r.buttons   = btn;
		r.has_stick = hs;
		r.horiz     = h[AXIS_W-1:0];
		r.vert      = v[AXIS_W-1:0];
		r.frame_end = fe;
		return r;
	endfunction

	function automatic logic [AXIS_W-1:0] to_axis(int dev);
		int raw;
		raw = 128 + dev;
		if (raw < 0)
			raw = 0;
		if (raw > 255)
			raw = 255;
		return raw[AXIS_W-1:0];
	endfunction

	function automatic word_t random_buttons();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
			2:       return word_t'($urandom);
			default: return (word_t'(1) << $urandom_range(0, WORD_W - 1)) |
				(word_t'(1) << $urandom_range(0, WORD_W - 1));
		endcase
	endfunction

	// half the draws are deflections close to the thresholds, where hysteresis matters
	function automatic pad_report_t random_report(bit last);
		pad_report_t r;
		int          thr;
		int          mag;
		int          minor;
		int          tmp;
		r.slot      = ($urandom_range(0, 9) == 0) ? 3'd7 :
			SLOT_W'($urandom_range(0, PAD_COUNT - 1));
		r.delivered = ($urandom_range(0, 6) != 0);
		r.buttons   = random_buttons();
		r.has_stick = ($urandom_range(0, 9) < 7);
		r.frame_end = last;
		case ($urandom_range(0, 5))
			0: begin
				r.horiz = AXIS_W'($urandom);
				r.vert  = AXIS_W'($urandom);
			end
			1: begin
				r.horiz = to_axis($urandom_range(0, 40) - 20);
				r.vert  = to_axis($urandom_range(0, 40) - 20);
			end
			2: begin
				r.horiz = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
				r.vert  = ($urandom_range(0, 2) == 0) ? 8'd128 : 8'd0;
			end
			default: begin
				thr   = ($urandom_range(0, 1) == 0) ? int'(sb.engage_thr) : int'(sb.keep_thr);
				mag   = thr + $urandom_range(0, 4) - 2;
				mag   = (mag < 0) ? 0 : (mag > 128 ? 128 : mag);
				minor = $urandom_range(0, mag);
				if ($urandom_range(0, 1) == 0)
					mag = -mag;
				if ($urandom_range(0, 1) == 0)
					minor = -minor;
				if ($urandom_range(0, 1) == 0) begin
					tmp   = mag;
					mag   = minor;
					minor = tmp;
				end
				r.horiz = to_axis(mag);
				r.vert  = to_axis(minor);
			end
		endcase
		return r;
	endfunction

	// offer one word after the drawn gap and hold it until taken
	task automatic send_report(input pad_report_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid         <= 1'b1;
		pad_slot         <= r.slot;
		delivered        <= r.delivered;
		button_bits      <= r.buttons;
		has_stick        <= r.has_stick;
		stick_horizontal <= r.horiz;
		stick_vertical   <= r.vert;
		frame_end        <= r.frame_end;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_report(r);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_thresholds(input logic [THR_W-1:0] eng, input logic [THR_W-1:0] keep);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ENGAGE;
		cfg_data  <= eng;
		@(negedge clk);
		cfg_index <= CFG_RELEASE;
		cfg_data  <= keep;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_register(CFG_ENGAGE, eng);
		sb.set_register(CFG_RELEASE, keep);
		settings_done++;
	endtask

	task automatic random_frames(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				send_report(random_report(i == len - 1));
			sent += len;
		end
	endtask

	task automatic run_phase(input logic [THR_W-1:0] eng, input logic [THR_W-1:0] keep,
		input int n_items, input bit hold);
		drain();
		write_thresholds(eng, keep);
		if (hold)
			long_hold_req = 1'b1;
		random_frames(n_items);
	endtask

	initial begin
		sb               = new();
		cycles           = 0;
		settings_done    = 0;
		quiet            = 1'b0;
		long_hold_req    = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_ENGAGE;
		cfg_data         = '0;
		in_valid         = 1'b0;
		pad_slot         = '0;
		delivered        = 1'b0;
		button_bits      = '0;
		has_stick        = 1'b0;
		stick_horizontal = 8'd128;
		stick_vertical   = 8'd128;
		frame_end        = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed frames under the reset thresholds
		send_report(mk(0, 1, 14'h0000, 1, 128, 128, 1));
		send_report(mk(0, 1, 14'h3fff, 1, 0, 128, 1));
		send_report(mk(6, 1, 14'h0010, 0, 128, 128, 0));
		send_report(mk(7, 1, 14'h3fff, 1, 255, 255, 1));
		send_report(mk(3, 0, 14'h3fff, 1, 0, 0, 1));
		send_report(mk(1, 1, 14'h0000, 0, 128, 128, 1));
		send_report(mk(1, 1, 14'h0020, 0, 128, 128, 1));
		send_report(mk(1, 1, 14'h0080, 0, 128, 128, 1));
		send_report(mk(1, 1, 14'h0400, 0, 128, 128, 1));
		send_report(mk(1, 1, 14'h0800, 0, 128, 128, 1));
		send_report(mk(1, 1, 14'h0030, 0, 128, 128, 1));
		// hold up through a weaker lean, drop it, then swap axis
		send_report(mk(2, 1, 14'h0000, 1, 128, 0, 1));
		send_report(mk(2, 1, 14'h0000, 1, 128, 68, 1));
		send_report(mk(2, 0, 14'h0000, 1, 255, 128, 1));
		send_report(mk(2, 1, 14'h0000, 1, 128, 88, 1));
		send_report(mk(2, 1, 14'h0000, 1, 255, 128, 1));
		send_report(mk(2, 1, 14'h0000, 1, 188, 228, 1));
		send_report(mk(4, 1, 14'h0000, 1, 0, 0, 0));
		send_report(mk(5, 1, 14'h0000, 1, 255, 255, 1));
		send_report(mk(7, 1, 14'h3fff, 1, 0, 0, 1));
		send_report(mk(6, 1, 14'h2000, 1, 128, 128, 0));
		send_report(mk(0, 1, 14'h1000, 0, 0, 0, 1));

		quiet = 1'b1;
		run_phase(8'd0, 8'd0, 90, 1'b0);
		quiet = 1'b0;
		run_phase(8'd128, 8'd128, 70, 1'b1);
		quiet = ($urandom_range(0, 3) == 0);
		run_phase(8'd0, 8'd128, 80, 1'b0);
		quiet = ($urandom_range(0, 3) == 0);
		run_phase(8'd128, 8'd0, 80, 1'b1);
		quiet = 1'b0;
		run_phase(ENGAGE_RESET, RELEASE_RESET, 90, 1'b0);
		run_phase(THR_W'($urandom_range(0, 128)), THR_W'($urandom_range(0, 128)), 90, 1'b0);
		drain();

		$display("summary: %0d pad words, %0d frame results checked over %0d threshold settings",
			sb.reports_noted, sb.frames_checked, settings_done);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
